[hw/rtl/aes_round_difference_stepper_macros.svh]
// Assertion macros used by the top RTL file of the difference stepper.
`ifndef AES_ROUND_DIFFERENCE_STEPPER_MACROS_SVH
`define AES_ROUND_DIFFERENCE_STEPPER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define ARDS_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define ARDS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ARDS_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define ARDS_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

[hw/rtl/aesrds_pkg.sv]
package aesrds_pkg;

    // 16-byte AES state, byte i at bits 8i+7:8i (row i/4, column i%4)
    typedef logic [15:0][7:0] aesrds_state_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // ShiftRows source byte for each destination byte
    localparam logic [3:0] SHIFT_SRC [16] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd4,
        4'd10, 4'd11, 4'd8, 4'd9, 4'd15, 4'd12, 4'd13, 4'd14
    };

    // MixColumns matrix, coefficients in {1,2,3}
    localparam logic [1:0] MIX_COEF [4][4] = '{
        '{2'd2, 2'd3, 2'd1, 2'd1},
        '{2'd1, 2'd2, 2'd3, 2'd1},
        '{2'd1, 2'd1, 2'd2, 2'd3},
        '{2'd3, 2'd1, 2'd1, 2'd2}
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return SBOX[b];
    endfunction

    // multiply by x modulo 0x11b
    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] coef_mul(input logic [1:0] c, input logic [7:0] a);
        return (c[0] ? a : 8'h00) ^ (c[1] ? xtime(a) : 8'h00);
    endfunction

endpackage

[hw/rtl/aesrds_round.sv]
module aesrds_round (
    input  aesrds_pkg::aesrds_state_t diff,       // round input difference
    input  aesrds_pkg::aesrds_state_t rnd,        // S-box input values
    output aesrds_pkg::aesrds_state_t sbox_diff,  // S-box output difference
    output aesrds_pkg::aesrds_state_t next_diff   // after ShiftRows and MixColumns
);
    import aesrds_pkg::*;

    aesrds_state_t shifted;

    for (genvar i = 0; i < 16; i++) begin : g_byte
        assign sbox_diff[i] = sbox(rnd[i]) ^ sbox(rnd[i] ^ diff[i]);
        assign shifted[i]   = sbox_diff[SHIFT_SRC[i]];
    end

    for (genvar r = 0; r < 4; r++) begin : g_row
        for (genvar c = 0; c < 4; c++) begin : g_col
            assign next_diff[4*r + c] = coef_mul(MIX_COEF[r][0], shifted[c])
                                      ^ coef_mul(MIX_COEF[r][1], shifted[4 + c])
                                      ^ coef_mul(MIX_COEF[r][2], shifted[8 + c])
                                      ^ coef_mul(MIX_COEF[r][3], shifted[12 + c]);
        end
    end

endmodule

[hw/rtl/aes_round_difference_stepper.sv]
// Tracks an AES difference through rounds. A load transaction (tuser = 0) sets the
// 16-byte difference from tdata bits 127:0 and returns nothing. A step transaction
// (tuser = 1) takes 16 S-box input bytes from tdata bits 255:128 and returns the
// difference before the S-box layer and the S-box output difference; the stored
// difference then advances through ShiftRows and MixColumns. One transaction is
// taken every cycle while no step waits on a stalled output; a step result passes
// through the input register, the combinational round logic and the result
// register, with the difference register feeding the next item back to back.
`include "aes_round_difference_stepper_macros.svh"

module aes_round_difference_stepper (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [255:0] s_tdata,   // data_lo, data_hi, rand_lo, rand_hi
    input  logic         s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata    // in_diff_lo, in_diff_hi, out_diff_lo, out_diff_hi
);
    import aesrds_pkg::*;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    logic          in_valid_reg;
    logic          in_valid_next;
    logic          in_action_reg;
    logic [255:0]  in_data_reg;
    aesrds_state_t diff_reg;
    aesrds_state_t diff_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    aesrds_state_t out_in_diff_reg;
    aesrds_state_t out_sbox_diff_reg;

    aesrds_state_t sbox_diff;
    aesrds_state_t round_diff;
    logic          out_free;
    logic          stage_go;
    logic          step_go;
    logic          s_accept;

    aesrds_round u_round (
        .diff      (diff_reg),
        .rnd       (in_data_reg[255:128]),
        .sbox_diff (sbox_diff),
        .next_diff (round_diff)
    );

    assign out_free = !out_valid_reg || m_tready;
    // a load needs no result slot, so only a step waits on the output side
    assign stage_go = in_valid_reg && (in_action_reg == ACT_LOAD || out_free);
    assign step_go  = stage_go && in_action_reg == ACT_STEP;
    assign s_tready = !in_valid_reg || stage_go;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (stage_go) begin
            in_valid_next = 1'b0;
        end

        diff_next = diff_reg;
        if (stage_go) begin
            diff_next = (in_action_reg == ACT_STEP) ? round_diff : in_data_reg[127:0];
        end

        out_valid_next = out_valid_reg;
        if (step_go) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            diff_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            diff_reg      <= diff_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_action_reg <= s_tuser;
            in_data_reg   <= s_tdata;
        end
        if (step_go) begin
            out_in_diff_reg   <= diff_reg;
            out_sbox_diff_reg <= sbox_diff;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_sbox_diff_reg, out_in_diff_reg};

    `ARDS_ASSERT_NEXT(a_step_yields_result, aclk, aresetn, step_go, m_tvalid)
    `ARDS_ASSERT_NEXT(a_result_carries_diff, aclk, aresetn, step_go,
                      out_in_diff_reg == $past(diff_reg))
    `ARDS_ASSERT_NEXT(a_load_sets_diff, aclk, aresetn,
                      in_valid_reg && in_action_reg == ACT_LOAD,
                      diff_reg == $past(in_data_reg[127:0]))
    `ARDS_ASSERT_NEXT(a_diff_holds_when_idle, aclk, aresetn, !stage_go, $stable(diff_reg))
    `ARDS_ASSERT_IMPLY(a_no_step_over_stall, aclk, aresetn, m_tvalid && !m_tready, !step_go)

endmodule
